[hw/rtl/bycs_pkg.sv]
// ============================================================================
// bycs_pkg - shared types and constants for the BGRA to YCbCr converter
// Pixel channel struct, chroma mode codes, BT.709 limited-range weights and
// small helpers for offsets and final chroma scaling.
// ============================================================================
`default_nettype none

package bycs_pkg;

    // One pixel, alpha dropped
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    // Chroma subsampling modes; the unused code behaves as 4:2:0
    typedef enum logic [1:0] {
        MODE_444 = 2'd0,
        MODE_422 = 2'd1,
        MODE_420 = 2'd2
    } chroma_mode_t;

    // Signed accumulator for chroma (sums over up to four pixels)
    typedef logic signed [19:0] chroma_acc_t;

    // Luma weights over 256, offset 16 plus rounding half
    localparam logic [15:0] LUMA_W_RED    = 16'd47;
    localparam logic [15:0] LUMA_W_GREEN  = 16'd157;
    localparam logic [15:0] LUMA_W_BLUE   = 16'd16;
    localparam logic [15:0] LUMA_OFFSET   = 16'd4224;

    // Chroma weights over 256, offset 128 plus rounding half
    localparam chroma_acc_t CB_W_RED      = -20'sd26;
    localparam chroma_acc_t CB_W_GREEN    = -20'sd86;
    localparam chroma_acc_t CB_W_BLUE     = 20'sd112;
    localparam chroma_acc_t CR_W_RED      = 20'sd112;
    localparam chroma_acc_t CR_W_GREEN    = -20'sd102;
    localparam chroma_acc_t CR_W_BLUE     = -20'sd10;
    localparam chroma_acc_t CHROMA_OFFSET = 20'sd32896;

    function automatic rgb_t unpack_rgb(input logic [31:0] px);
        rgb_t c;
        c.red   = px[23:16];
        c.green = px[15:8];
        c.blue  = px[7:0];
        return c;
    endfunction

    // Zero-extend a channel sum into the signed accumulator
    function automatic chroma_acc_t widen(input logic [9:0] s);
        return chroma_acc_t'({10'd0, s});
    endfunction

    // Offset scaled by the group size
    function automatic chroma_acc_t chroma_offset(input chroma_mode_t m);
        chroma_acc_t off;
        case (m)
            MODE_444: off = CHROMA_OFFSET;
            MODE_422: off = CHROMA_OFFSET <<< 1;
            default:  off = CHROMA_OFFSET <<< 2;
        endcase
        return off;
    endfunction

    // Clamp at zero, then divide by 256 times the group size
    function automatic logic [7:0] scale_chroma(input chroma_acc_t acc,
                                                input chroma_mode_t m);
        logic [7:0] v;
        if (acc[19]) begin
            v = 8'd0;
        end
        else begin
            case (m)
                MODE_444: v = acc[15:8];
                MODE_422: v = acc[16:9];
                default:  v = acc[17:10];
            endcase
        end
        return v;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/bycs_luma.sv]
// ============================================================================
// bycs_luma - three-stage luma pipeline for one pixel
// Weighted products, sum with offset, then scale and zero when unused.
// ============================================================================
`default_nettype none

module bycs_luma (
    input  logic           clk,
    input  bycs_pkg::rgb_t px,
    input  logic           en,
    output logic [7:0]     luma
);

    logic [15:0] red_term_reg;
    logic [15:0] green_term_reg;
    logic [15:0] blue_term_reg;
    logic        en_prod_reg;
    logic [15:0] acc_reg;
    logic [15:0] acc_next;
    logic        en_acc_reg;
    logic [7:0]  luma_reg;
    logic [7:0]  luma_next;

    // Stage: weighted products
    always_ff @(posedge clk)
    begin
        red_term_reg   <= 16'(px.red) * bycs_pkg::LUMA_W_RED;
        green_term_reg <= 16'(px.green) * bycs_pkg::LUMA_W_GREEN;
        blue_term_reg  <= 16'(px.blue) * bycs_pkg::LUMA_W_BLUE;
        en_prod_reg    <= en;
    end

    // Stage: sum plus offset (max 60324, fits 16 bits)
    assign acc_next = red_term_reg + green_term_reg + blue_term_reg
                    + bycs_pkg::LUMA_OFFSET;

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        en_acc_reg <= en_prod_reg;
    end

    // Stage: divide by 256, unused pixels read zero
    assign luma_next = en_acc_reg ? acc_reg[15:8] : 8'd0;

    always_ff @(posedge clk)
    begin
        luma_reg <= luma_next;
    end

    assign luma = luma_reg;

endmodule

`default_nettype wire

[hw/rtl/bgra_to_ycbcr_subsample.sv]
// ============================================================================
// bgra_to_ycbcr_subsample - BGRA to BT.709 limited-range YCbCr, 4:4:4/2:2/2:0
// Four-stage pipeline: capture and channel sums, products, sums with
// offsets, scaling into the output registers.
//
//   Channel  | Signals                              | Dir | Transfer
//   ---------+--------------------------------------+-----+---------------------
//   input    | start, busy, pixel_a..pixel_d        | in  | start & !busy
//   result   | done, luma_a..luma_d, chroma_blue/red| out | done, one cycle
//   config   | cfg_wr_en, cfg_wr_data               | in  | cfg_wr_en
//
// One pixel group per cycle; the done strobe follows the input transfer through
// the four pipeline register stages.
// busy is always low: the pipeline never stalls and results are not held.
// Reset clears the stage valid bits and sets chroma_mode to 4:4:4.
// The mode is sampled with each item and travels down with it.
// ============================================================================
`default_nettype none

module bgra_to_ycbcr_subsample (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] pixel_a,
    input  logic [31:0] pixel_b,
    input  logic [31:0] pixel_c,
    input  logic [31:0] pixel_d,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_wr_data,
    output logic        done,
    output logic [7:0]  luma_a,
    output logic [7:0]  luma_b,
    output logic [7:0]  luma_c,
    output logic [7:0]  luma_d,
    output logic [7:0]  chroma_blue,
    output logic [7:0]  chroma_red
);

    bycs_pkg::chroma_mode_t mode_reg;

    // Stage 1 signals
    bycs_pkg::rgb_t         px_next [4];
    bycs_pkg::rgb_t         px_reg  [4];
    bycs_pkg::chroma_mode_t mode1_next;
    bycs_pkg::chroma_mode_t mode1_reg;
    logic [3:0]             en_next;
    logic [3:0]             en_reg;
    logic [9:0]             sum_red_next;
    logic [9:0]             sum_green_next;
    logic [9:0]             sum_blue_next;
    logic [9:0]             sum_red_reg;
    logic [9:0]             sum_green_reg;
    logic [9:0]             sum_blue_reg;
    logic                   valid1_reg;

    // Stage 2 signals
    bycs_pkg::chroma_acc_t  cb_red_reg;
    bycs_pkg::chroma_acc_t  cb_green_reg;
    bycs_pkg::chroma_acc_t  cb_blue_reg;
    bycs_pkg::chroma_acc_t  cr_red_reg;
    bycs_pkg::chroma_acc_t  cr_green_reg;
    bycs_pkg::chroma_acc_t  cr_blue_reg;
    bycs_pkg::chroma_mode_t mode2_reg;
    logic                   valid2_reg;

    // Stage 3 signals
    bycs_pkg::chroma_acc_t  cb_acc_next;
    bycs_pkg::chroma_acc_t  cr_acc_next;
    bycs_pkg::chroma_acc_t  cb_acc_reg;
    bycs_pkg::chroma_acc_t  cr_acc_reg;
    bycs_pkg::chroma_mode_t mode3_reg;
    logic                   valid3_reg;

    // Output stage signals
    logic [7:0]             cb_out_next;
    logic [7:0]             cr_out_next;
    logic [7:0]             cb_out_reg;
    logic [7:0]             cr_out_reg;
    bycs_pkg::chroma_mode_t mode_out_reg;
    logic                   done_reg;

    assign busy = 1'b0;

    // Mode register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg <= bycs_pkg::MODE_444;
        end
        else if (cfg_wr_en) begin
            mode_reg <= bycs_pkg::chroma_mode_t'(cfg_wr_data);
        end
    end

    // Stage 1: unpack, pick used pixels, channel sums
    assign px_next[0] = bycs_pkg::unpack_rgb(pixel_a);
    assign px_next[1] = bycs_pkg::unpack_rgb(pixel_b);
    assign px_next[2] = bycs_pkg::unpack_rgb(pixel_c);
    assign px_next[3] = bycs_pkg::unpack_rgb(pixel_d);

    always_comb
    begin
        case (mode_reg)
            bycs_pkg::MODE_444: begin
                mode1_next = bycs_pkg::MODE_444;
                en_next    = 4'b0001;
            end
            bycs_pkg::MODE_422: begin
                mode1_next = bycs_pkg::MODE_422;
                en_next    = 4'b0011;
            end
            default: begin
                mode1_next = bycs_pkg::MODE_420;
                en_next    = 4'b1111;
            end
        endcase
        sum_red_next   = 10'd0;
        sum_green_next = 10'd0;
        sum_blue_next  = 10'd0;
        for (int i = 0; i < 4; i++) begin
            if (en_next[i]) begin
                sum_red_next   = sum_red_next + 10'(px_next[i].red);
                sum_green_next = sum_green_next + 10'(px_next[i].green);
                sum_blue_next  = sum_blue_next + 10'(px_next[i].blue);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 4; i++) begin
            px_reg[i] <= px_next[i];
        end
        en_reg        <= en_next;
        mode1_reg     <= mode1_next;
        sum_red_reg   <= sum_red_next;
        sum_green_reg <= sum_green_next;
        sum_blue_reg  <= sum_blue_next;
    end

    // Stage 2: chroma products
    always_ff @(posedge clk)
    begin
        cb_red_reg   <= bycs_pkg::widen(sum_red_reg) * bycs_pkg::CB_W_RED;
        cb_green_reg <= bycs_pkg::widen(sum_green_reg) * bycs_pkg::CB_W_GREEN;
        cb_blue_reg  <= bycs_pkg::widen(sum_blue_reg) * bycs_pkg::CB_W_BLUE;
        cr_red_reg   <= bycs_pkg::widen(sum_red_reg) * bycs_pkg::CR_W_RED;
        cr_green_reg <= bycs_pkg::widen(sum_green_reg) * bycs_pkg::CR_W_GREEN;
        cr_blue_reg  <= bycs_pkg::widen(sum_blue_reg) * bycs_pkg::CR_W_BLUE;
        mode2_reg    <= mode1_reg;
    end

    // Stage 3: sums with scaled offset
    assign cb_acc_next = cb_red_reg + cb_green_reg + cb_blue_reg
                       + bycs_pkg::chroma_offset(mode2_reg);
    assign cr_acc_next = cr_red_reg + cr_green_reg + cr_blue_reg
                       + bycs_pkg::chroma_offset(mode2_reg);

    always_ff @(posedge clk)
    begin
        cb_acc_reg <= cb_acc_next;
        cr_acc_reg <= cr_acc_next;
        mode3_reg  <= mode2_reg;
    end

    // Output stage: clamp and scale
    assign cb_out_next = bycs_pkg::scale_chroma(cb_acc_reg, mode3_reg);
    assign cr_out_next = bycs_pkg::scale_chroma(cr_acc_reg, mode3_reg);

    always_ff @(posedge clk)
    begin
        cb_out_reg   <= cb_out_next;
        cr_out_reg   <= cr_out_next;
        mode_out_reg <= mode3_reg;
    end

    // Valid bits down the pipe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
            valid3_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else begin
            valid1_reg <= start & ~busy;
            valid2_reg <= valid1_reg;
            valid3_reg <= valid2_reg;
            done_reg   <= valid3_reg;
        end
    end

    // Luma lanes, aligned with the chroma path
    bycs_luma u_luma_a (.clk(clk), .px(px_reg[0]), .en(en_reg[0]), .luma(luma_a));
    bycs_luma u_luma_b (.clk(clk), .px(px_reg[1]), .en(en_reg[1]), .luma(luma_b));
    bycs_luma u_luma_c (.clk(clk), .px(px_reg[2]), .en(en_reg[2]), .luma(luma_c));
    bycs_luma u_luma_d (.clk(clk), .px(px_reg[3]), .en(en_reg[3]), .luma(luma_d));

    assign done        = done_reg;
    assign chroma_blue = cb_out_reg;
    assign chroma_red  = cr_out_reg;

    // Every transfer yields exactly one done strobe
    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##4 done)
        else $error("missing done after input transfer");

    a_no_spurious_done: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |-> ##4 !done)
        else $error("done without input transfer");

    // Unused luma lanes read zero
    a_unused_luma: assert property (@(posedge clk) disable iff (!rst_n)
        (done && mode_out_reg != bycs_pkg::MODE_420) |->
            (luma_c == 8'd0 && luma_d == 8'd0 &&
             (mode_out_reg != bycs_pkg::MODE_444 || luma_b == 8'd0)))
        else $error("unused luma lane not zero");

    // Limited range holds on luma_a and both chroma outputs of every result
    a_luma_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (luma_a >= 8'd16 && luma_a <= 8'd235))
        else $error("luma out of limited range");

    a_chroma_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (chroma_blue >= 8'd16 && chroma_blue <= 8'd240 &&
                  chroma_red >= 8'd16 && chroma_red <= 8'd240))
        else $error("chroma out of limited range");

endmodule

`default_nettype wire

[verif/tb.sv]
// ============================================================================
// tb - testbench for bgra_to_ycbcr_subsample
// Drives BGRA pixel groups through the converter in every chroma mode and
// checks each luma/chroma result, field by field, against an in-bench
// fixed-point prediction kept in transfer order. A short table of directed
// groups (extremes, primaries, ignored pixels and alpha, the spare mode) is
// followed by random phases, each at one mode, with random sender gaps.
// ============================================================================
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Mode codes as plain register values
    localparam logic [1:0] MODE_444   = bycs_pkg::MODE_444;
    localparam logic [1:0] MODE_422   = bycs_pkg::MODE_422;
    localparam logic [1:0] MODE_420   = bycs_pkg::MODE_420;
    // Spare mode code, converts as 4:2:0
    localparam logic [1:0] MODE_SPARE = 2'd3;

    // BT.709 limited-range weights over 256, offsets include the rounding half
    localparam int Y_W_RED    = 47;
    localparam int Y_W_GREEN  = 157;
    localparam int Y_W_BLUE   = 16;
    localparam int Y_BIAS     = 128 + (16 << 8);
    localparam int CB_W_RED   = -26;
    localparam int CB_W_GREEN = -86;
    localparam int CB_W_BLUE  = 112;
    localparam int CR_W_RED   = 112;
    localparam int CR_W_GREEN = -102;
    localparam int CR_W_BLUE  = -10;
    localparam int C_BIAS     = 128 + (128 << 8);

    localparam int RANDOM_ITEMS = 1000;

    // One converted group
    typedef struct packed {
        logic [7:0] y_a;
        logic [7:0] y_b;
        logic [7:0] y_c;
        logic [7:0] y_d;
        logic [7:0] cb;
        logic [7:0] cr;
    } ycc_t;

    // One directed group; want is used only where typed is set
    typedef struct {
        logic [1:0]  mode;
        logic [31:0] pa;
        logic [31:0] pb;
        logic [31:0] pc;
        logic [31:0] pd;
        bit          typed;
        ycc_t        want;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [31:0] pixel_a;
    logic [31:0] pixel_b;
    logic [31:0] pixel_c;
    logic [31:0] pixel_d;
    logic        cfg_wr_en;
    logic [1:0]  cfg_wr_data;
    logic        done;
    logic [7:0]  luma_a;
    logic [7:0]  luma_b;
    logic [7:0]  luma_c;
    logic [7:0]  luma_d;
    logic [7:0]  chroma_blue;
    logic [7:0]  chroma_red;

    ycc_t        ycc_due[$];
    stim_row_t   plan[$];
    ycc_t        oldest;
    logic [1:0]  cur_mode;
    int          mismatches;

    bgra_to_ycbcr_subsample dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .pixel_a     (pixel_a),
        .pixel_b     (pixel_b),
        .pixel_c     (pixel_c),
        .pixel_d     (pixel_d),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .done        (done),
        .luma_a      (luma_a),
        .luma_b      (luma_b),
        .luma_c      (luma_c),
        .luma_d      (luma_d),
        .chroma_blue (chroma_blue),
        .chroma_red  (chroma_red)
    );

    // 10 ns clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Expected conversion of one group at the given mode
    function automatic ycc_t convert_group(input logic [1:0] mode,
                                           input logic [31:0] pa, pb, pc, pd);
        logic [31:0]    pix [4];
        logic [7:0]     y [4];
        bycs_pkg::rgb_t c;
        int             lg;
        int             i;
        int             sum_r;
        int             sum_g;
        int             sum_b;
        int             acc;
        int             acc_cb;
        int             acc_cr;
        ycc_t           res;
        pix[0] = pa;
        pix[1] = pb;
        pix[2] = pc;
        pix[3] = pd;
        lg = (mode == MODE_444) ? 0 : (mode == MODE_422) ? 1 : 2;
        sum_r = 0;
        sum_g = 0;
        sum_b = 0;
        for (i = 0; i < 4; i++)
            y[i] = 8'd0;
        // Luma per used pixel, channel sums over the group
        for (i = 0; i < (1 << lg); i++)
        begin
            c = bycs_pkg::rgb_t'(pix[i][23:0]);
            acc = Y_W_RED * int'(c.red) + Y_W_GREEN * int'(c.green)
                  + Y_W_BLUE * int'(c.blue) + Y_BIAS;
            y[i] = 8'((acc >> 8) & 255);
            sum_r += int'(c.red);
            sum_g += int'(c.green);
            sum_b += int'(c.blue);
        end
        acc_cb = CB_W_RED * sum_r + CB_W_GREEN * sum_g + CB_W_BLUE * sum_b
                 + (C_BIAS << lg);
        acc_cr = CR_W_RED * sum_r + CR_W_GREEN * sum_g + CR_W_BLUE * sum_b
                 + (C_BIAS << lg);
        if (acc_cb < 0)
            acc_cb = 0;
        if (acc_cr < 0)
            acc_cr = 0;
        res.y_a = y[0];
        res.y_b = y[1];
        res.y_c = y[2];
        res.y_d = y[3];
        res.cb  = 8'((acc_cb >> (8 + lg)) & 255);
        res.cr  = 8'((acc_cr >> (8 + lg)) & 255);
        return res;
    endfunction

    // Mostly full-random pixels, some with every byte at 0x00 or 0xFF
    function automatic logic [31:0] rand_pixel();
        logic [31:0] px;
        int          k;
        if ($urandom_range(0, 7) < 6)
            return $urandom;
        for (k = 0; k < 4; k++)
            px[k*8 +: 8] = ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
        return px;
    endfunction

    // Sender gap: mostly none, some short, a few long
    function automatic int pick_gap(input bit burst);
        int r;
        if (burst)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    task automatic add_row(input logic [1:0] mode, input logic [31:0] pa, pb, pc, pd,
                           input bit typed, input ycc_t want);
        stim_row_t row;
        row.mode  = mode;
        row.pa    = pa;
        row.pb    = pb;
        row.pc    = pc;
        row.pd    = pd;
        row.typed = typed;
        row.want  = want;
        plan.push_back(row);
    endtask

    // One input transfer; the expectation is queued at the accepting edge
    task automatic send_group(input logic [31:0] pa, pb, pc, pd,
                              input bit typed, input ycc_t want);
        start   <= 1'b1;
        pixel_a <= pa;
        pixel_b <= pb;
        pixel_c <= pc;
        pixel_d <= pd;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        ycc_due.push_back(typed ? want : convert_group(cur_mode, pa, pb, pc, pd));
    endtask

    task automatic pause_sender(input int n);
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // Stop sending and wait for every outstanding result
    task automatic wait_drained();
        start <= 1'b0;
        while (ycc_due.size() != 0)
            @(posedge clk);
    endtask

    // Mode change only with the pipeline empty
    task automatic set_mode(input logic [1:0] m);
        wait_drained();
        cfg_wr_data <= m;
        cfg_wr_en   <= 1'b1;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        cur_mode = m;
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // Result checker: every done strobe is one transfer
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (ycc_due.size() == 0)
            begin
                $error("result transfer with no expectation pending");
                mismatches++;
            end
            else
            begin
                oldest = ycc_due.pop_front();
                check_field("luma_a", oldest.y_a, luma_a);
                check_field("luma_b", oldest.y_b, luma_b);
                check_field("luma_c", oldest.y_c, luma_c);
                check_field("luma_d", oldest.y_d, luma_d);
                check_field("chroma_blue", oldest.cb, chroma_blue);
                check_field("chroma_red", oldest.cr, chroma_red);
            end
        end
    end

    // Main sequence
    initial
    begin
        int   sent;
        int   n;
        int   i;
        int   phase;
        bit   burst;
        logic [1:0] m;

        rst_n       = 1'b0;
        start       = 1'b0;
        pixel_a     = '0;
        pixel_b     = '0;
        pixel_c     = '0;
        pixel_d     = '0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        cur_mode    = MODE_444;
        mismatches  = 0;

        // Directed groups; first rows run at the reset mode without a write
        add_row(MODE_444, 32'h0000_0000, 32'h0, 32'h0, 32'h0, 1,
                {8'd16, 8'd0, 8'd0, 8'd0, 8'd128, 8'd128});
        add_row(MODE_444, 32'h00FF_FFFF, 32'h0, 32'h0, 32'h0, 1,
                {8'd235, 8'd0, 8'd0, 8'd0, 8'd128, 8'd128});
        // alpha alone must not change anything
        add_row(MODE_444, 32'hFF00_0000, 32'h0, 32'h0, 32'h0, 1,
                {8'd16, 8'd0, 8'd0, 8'd0, 8'd128, 8'd128});
        add_row(MODE_444, 32'h00FF_0000, 32'h0, 32'h0, 32'h0, 1,
                {8'd63, 8'd0, 8'd0, 8'd0, 8'd102, 8'd240});
        add_row(MODE_444, 32'h0000_FF00, 32'h0, 32'h0, 32'h0, 1,
                {8'd172, 8'd0, 8'd0, 8'd0, 8'd42, 8'd26});
        add_row(MODE_444, 32'h0000_00FF, 32'h0, 32'h0, 32'h0, 1,
                {8'd32, 8'd0, 8'd0, 8'd0, 8'd240, 8'd118});
        // unused pixels ignored, unused luma zero
        add_row(MODE_444, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1,
                {8'd235, 8'd0, 8'd0, 8'd0, 8'd128, 8'd128});
        add_row(MODE_422, 32'h0000_0000, 32'h00FF_FFFF, 32'h0, 32'h0, 0, '0);
        add_row(MODE_422, 32'h00FF_0000, 32'h0000_00FF, 32'h0, 32'h0, 0, '0);
        add_row(MODE_422, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1,
                {8'd235, 8'd235, 8'd0, 8'd0, 8'd128, 8'd128});
        add_row(MODE_422, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1,
                {8'd16, 8'd16, 8'd0, 8'd0, 8'd128, 8'd128});
        add_row(MODE_420, 32'h0000_0000, 32'h0, 32'h0, 32'h0, 1,
                {8'd16, 8'd16, 8'd16, 8'd16, 8'd128, 8'd128});
        add_row(MODE_420, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1,
                {8'd235, 8'd235, 8'd235, 8'd235, 8'd128, 8'd128});
        add_row(MODE_420, 32'h00FF_0000, 32'h0000_FF00, 32'h0000_00FF, 32'h00FF_FFFF,
                0, '0);
        add_row(MODE_420, 32'h00FF_00FF, 32'h0000_FFFF, 32'h00FF_FF00, 32'h0000_0000,
                0, '0);
        add_row(MODE_420, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 32'hA5A5_A5A5, 32'h5A5A_5A5A,
                0, '0);
        // spare mode code behaves as 4:2:0
        add_row(MODE_SPARE, 32'h0000_0000, 32'h0, 32'h0, 32'h0, 1,
                {8'd16, 8'd16, 8'd16, 8'd16, 8'd128, 8'd128});
        add_row(MODE_SPARE, 32'h00FF_0000, 32'h00FF_0000, 32'h0000_00FF, 32'h0000_00FF,
                0, '0);
        add_row(MODE_SPARE, 32'h1234_5678, 32'h9ABC_DEF0, 32'h0F1E_2D3C, 32'hF0E1_D2C3,
                0, '0);
        add_row(MODE_444, 32'h0080_8080, 32'h0, 32'h0, 32'h0, 0, '0);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table
        for (i = 0; i < plan.size(); i++)
        begin
            if (plan[i].mode != cur_mode)
                set_mode(plan[i].mode);
            send_group(plan[i].pa, plan[i].pb, plan[i].pc, plan[i].pd,
                       plan[i].typed, plan[i].want);
            pause_sender(pick_gap(0));
        end

        // Random phases: all four codes first, then random ones
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS)
        begin
            case (phase)
                0: m = MODE_444;
                1: m = MODE_SPARE;
                2: m = MODE_422;
                3: m = MODE_420;
                default: m = 2'($urandom_range(0, 3));
            endcase
            set_mode(m);
            burst = ($urandom_range(0, 3) == 0);
            n = $urandom_range(60, 200);
            for (i = 0; i < n && sent < RANDOM_ITEMS; i++)
            begin
                send_group(rand_pixel(), rand_pixel(), rand_pixel(), rand_pixel(), 0, '0);
                sent++;
                pause_sender(pick_gap(burst));
            end
            phase++;
        end

        // Drain, then a few quiet cycles to catch stray strobes
        wait_drained();
        repeat (10) @(posedge clk);
        if (mismatches == 0 && ycc_due.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Watchdog
    initial
    begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire
